// ===== rtl/core/ddsm_pkg.sv =====
// Shared types and constants of the differential drive speed mixer.
// No dependencies; every other file of the block uses this package.
package ddsm_pkg;

  localparam int ERR_W   = 13;
  localparam int CORR_W  = 16;
  localparam int SPEED_W = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Quotient of the Q1.16 magnitude, and the pipelined divider layout.
  localparam int Q_BITS         = 16;
  localparam int DIV_STAGES     = 8;
  localparam int DIV_STEP_BITS  = Q_BITS / DIV_STAGES;

  // floor(e * 1024 / 125) == (e * TAPER_RECIP) >> TAPER_SHIFT for e below 4096.
  localparam logic [23:0] TAPER_RECIP = 24'd8589935;
  localparam int          TAPER_SHIFT = 20;
  localparam logic [16:0] TAPER_BASE  = 17'd73728;
  localparam logic [16:0] Q_ONE       = 17'd65536;

  localparam logic signed [ERR_W-1:0] TAPER_START = 13'sd1000;
  localparam logic signed [ERR_W-1:0] TAPER_NEG   = -13'sd1000;
  localparam logic signed [9:0]       INNER_FLOOR = 10'sd20;
  localparam logic signed [9:0]       SPEED_CEIL  = 10'sd255;

  localparam logic [CFG_IDX_W-1:0] CFG_PID_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd3;

  // Word carried from the front stage through the divider stages.
  typedef struct packed {
    logic        right;
    logic        sat;
    logic        taper;
    logic        inner_clamp;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [35:0] cprod;
    logic [15:0] ad;
    logic [15:0] rem;
    logic [Q_BITS-1:0] q;
  } pipe_t;

endpackage

// ===== rtl/core/ddsm_if.sv =====
// Valid/ready channel interfaces of the speed mixer: sensor input and speed output.
// Depends on ddsm_pkg for the field widths.
interface ddsm_in_if;
  logic valid;
  logic ready;
  logic signed [ddsm_pkg::ERR_W-1:0]  line_error;
  logic signed [ddsm_pkg::CORR_W-1:0] correction;

  modport source (output valid, output line_error, output correction, input ready);
  modport sink   (input valid, input line_error, input correction, output ready);
endinterface

interface ddsm_out_if;
  logic valid;
  logic ready;
  logic signed [ddsm_pkg::SPEED_W-1:0] left_speed;
  logic signed [ddsm_pkg::SPEED_W-1:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

// ===== rtl/core/ddsm_front.sv =====
// Front stage: range mapping operands, saturation test and taper product.
// Depends on ddsm_pkg.
module ddsm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [ddsm_pkg::ERR_W-1:0]   line_error,
  input  logic signed [ddsm_pkg::CORR_W-1:0]  correction,
  input  logic signed [15:0]                  pid_low,
  input  logic signed [15:0]                  pid_high,
  input  logic [7:0]                          max_speed,
  input  logic [7:0]                          min_speed,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output ddsm_pkg::pipe_t                     dn_data
);
  import ddsm_pkg::*;

  logic         valid_r;
  pipe_t        data_r;
  pipe_t        data_nxt;
  logic [18:0]  num;
  logic [18:0]  an;
  logic [16:0]  den;
  logic [16:0]  ad_full;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    num = {{2{correction[15]}}, correction, 1'b0}
        - {{3{pid_low[15]}}, pid_low}
        - {{3{pid_high[15]}}, pid_high};
    an  = num[18] ? 19'(-num) : num;
    den = {pid_high[15], pid_high} - {pid_low[15], pid_low};
    ad_full = den[16] ? 17'(-den) : den;

    data_nxt.right = !correction[15];
    data_nxt.ad    = ad_full[15:0];
    // An empty range and a correction outside the range both give full turn.
    data_nxt.sat   = (ad_full[15:0] == 16'd0) || (an[17:0] >= {2'b00, ad_full[15:0]});
    data_nxt.rem   = an[15:0];
    data_nxt.q     = '0;
    data_nxt.taper = (line_error >= TAPER_START);
    data_nxt.inner_clamp = (line_error > TAPER_NEG) && (line_error < TAPER_START);
    data_nxt.mx    = max_speed;
    data_nxt.mn    = min_speed;
    data_nxt.cprod = 36'(line_error[11:0]) * 36'(TAPER_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/ddsm_divider.sv =====
// Pipelined restoring divider: Q1.16 magnitude quotient, two bits per stage.
// Depends on ddsm_pkg.
module ddsm_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  ddsm_pkg::pipe_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ddsm_pkg::pipe_t  dn_data
);
  import ddsm_pkg::*;

  logic  [DIV_STAGES-1:0] valid_r;
  logic  [DIV_STAGES-1:0] rdy;
  pipe_t                  stage_r   [DIV_STAGES];
  pipe_t                  stage_nxt [DIV_STAGES];

  // One remainder doubling with a trial subtract per quotient bit.
  function automatic pipe_t div_steps(input pipe_t p);
    pipe_t       o;
    logic [16:0] t;
    o = p;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t = {o.rem, 1'b0};
      if (t >= {1'b0, o.ad}) begin
        o.rem = 16'(t - {1'b0, o.ad});
        o.q   = {o.q[Q_BITS-2:0], 1'b1};
      end else begin
        o.rem = t[15:0];
        o.q   = {o.q[Q_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      if (k == DIV_STAGES - 1) begin
        rdy[k] = !valid_r[k] || dn_ready;
      end else begin
        rdy[k] = !valid_r[k] || rdy[k+1];
      end
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        stage_nxt[k] = div_steps(up_data);
      end else begin
        stage_nxt[k] = div_steps(stage_r[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= (k == 0) ? up_valid : valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && ((k == 0) ? up_valid : valid_r[k-1])) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = valid_r[DIV_STAGES-1];
  assign dn_data  = stage_r[DIV_STAGES-1];

endmodule

// ===== rtl/core/ddsm_back.sv =====
// Back stages: inner speed, taper scaling, clamping and side selection.
// Depends on ddsm_pkg; its last stage is the output register.
module ddsm_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  ddsm_pkg::pipe_t                      up_data,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [ddsm_pkg::SPEED_W-1:0]  left_speed,
  output logic signed [ddsm_pkg::SPEED_W-1:0]  right_speed
);
  import ddsm_pkg::*;

  typedef struct packed {
    logic               right;
    logic               inner_clamp;
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic signed [27:0] prod;
    logic [16:0]        c;
  } ba_t;

  typedef struct packed {
    logic               right;
    logic               inner_clamp;
    logic [7:0]         mn;
    logic signed [27:0] ip;
    logic [24:0]        op;
  } bb_t;

  logic  va_r, vb_r, vc_r;
  logic  rdy_a, rdy_b, rdy_c;
  ba_t   a_r, a_nxt;
  bb_t   b_r, b_nxt;
  logic signed [SPEED_W-1:0] left_r, left_nxt;
  logic signed [SPEED_W-1:0] right_r, right_nxt;

  logic [16:0]        m;
  logic signed [18:0] d;
  logic [15:0]        cq;
  logic signed [27:0] prod_rnd;
  logic signed [9:0]  inner0;
  logic signed [27:0] ip_rnd;
  logic signed [9:0]  inner;
  logic signed [9:0]  outer;

  assign rdy_c = !vc_r || dn_ready;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign up_ready = rdy_a;

  // Stage A: speed scale factor 1 - 2m and the taper coefficient.
  always_comb begin
    m  = up_data.sat ? Q_ONE : {1'b0, up_data.q};
    d  = $signed({2'b00, Q_ONE}) - $signed({1'b0, m, 1'b0});
    cq = up_data.cprod[TAPER_SHIFT +: 16];
    a_nxt.right       = up_data.right;
    a_nxt.inner_clamp = up_data.inner_clamp;
    a_nxt.mx          = up_data.mx;
    a_nxt.mn          = up_data.mn;
    a_nxt.prod        = $signed({1'b0, up_data.mx}) * d;
    a_nxt.c           = up_data.taper ? 17'(TAPER_BASE - {1'b0, cq}) : Q_ONE;
  end

  // Stage B: truncate the inner speed toward zero, then apply the taper.
  always_comb begin
    prod_rnd = a_r.prod + (a_r.prod[27] ? 28'sd65535 : 28'sd0);
    inner0   = prod_rnd[25:16];
    b_nxt.right       = a_r.right;
    b_nxt.inner_clamp = a_r.inner_clamp;
    b_nxt.mn          = a_r.mn;
    b_nxt.ip          = $signed({{18{inner0[9]}}, inner0}) * $signed({11'd0, a_r.c});
    b_nxt.op          = a_r.mx * a_r.c;
  end

  // Stage C: truncate, clamp and pick which motor is the inner one.
  always_comb begin
    ip_rnd = b_r.ip + (b_r.ip[27] ? 28'sd65535 : 28'sd0);
    inner  = ip_rnd[25:16];
    outer  = $signed({1'b0, b_r.op[24:16]});
    if (outer < $signed({2'b00, b_r.mn})) begin
      outer = $signed({2'b00, b_r.mn});
    end else if (outer > SPEED_CEIL) begin
      outer = SPEED_CEIL;
    end
    if (b_r.inner_clamp) begin
      if (inner < INNER_FLOOR) begin
        inner = INNER_FLOOR;
      end else if (inner > SPEED_CEIL) begin
        inner = SPEED_CEIL;
      end
    end
    left_nxt  = b_r.right ? outer[8:0] : inner[8:0];
    right_nxt = b_r.right ? inner[8:0] : outer[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= up_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      a_r <= a_nxt;
    end
    if (rdy_b && va_r) begin
      b_r <= b_nxt;
    end
    if (rdy_c && vb_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign dn_valid    = vc_r;
  assign left_speed  = left_r;
  assign right_speed = right_r;

endmodule

// ===== rtl/core/differential_drive_speed_mixer.sv =====
// Top level of the differential drive speed mixer: configuration registers and pipeline.
// Depends on ddsm_pkg, ddsm_if, ddsm_front, ddsm_divider and ddsm_back.

// The mixer takes one word (line error and steering correction) per clock cycle
// while no stalled output holds the pipeline, and returns one word of signed left
// and right motor speeds for each, in order. The result word passes through twelve
// register stages: one front stage, eight divider stages that resolve two quotient
// bits each of the Q1.16 turn magnitude, and three stages for the inner speed, the
// taper product and the clamps. Every stage holds its word while the next one is
// full and cannot pass its word on, so empty stages keep accepting while a result
// waits at the output. Registers pid_low, pid_high, max_speed and min_speed
// (indexes 0 to 3) are to be written through the cfg port by the user only while
// the pipeline is empty; the block does not enforce this. There is no clearing pass after reset.
module differential_drive_speed_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  ddsm_in_if.sink                            in_ch,
  ddsm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [ddsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddsm_pkg::CFG_W-1:0]         cfg_wdata
);
  import ddsm_pkg::*;

  logic signed [15:0] pid_low_r;
  logic signed [15:0] pid_high_r;
  logic [7:0]         max_speed_r;
  logic [7:0]         min_speed_r;

  logic  fr_valid, fr_ready;
  pipe_t fr_data;
  logic  dv_valid, dv_ready;
  pipe_t dv_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_low_r   <= -16'sd1000;
      pid_high_r  <= 16'sd1000;
      max_speed_r <= 8'd150;
      min_speed_r <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PID_LOW:   pid_low_r   <= $signed(cfg_wdata);
        CFG_PID_HIGH:  pid_high_r  <= $signed(cfg_wdata);
        CFG_MAX_SPEED: max_speed_r <= cfg_wdata[7:0];
        CFG_MIN_SPEED: min_speed_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ddsm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_ch.valid),
    .up_ready   (in_ch.ready),
    .line_error (in_ch.line_error),
    .correction (in_ch.correction),
    .pid_low    (pid_low_r),
    .pid_high   (pid_high_r),
    .max_speed  (max_speed_r),
    .min_speed  (min_speed_r),
    .dn_valid   (fr_valid),
    .dn_ready   (fr_ready),
    .dn_data    (fr_data)
  );

  ddsm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_data  (fr_data),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_data  (dv_data)
  );

  ddsm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (dv_valid),
    .up_ready    (dv_ready),
    .up_data     (dv_data),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .left_speed  (out_ch.left_speed),
    .right_speed (out_ch.right_speed)
  );

  // With the output stage free, every stage can move, so the input must be open.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked while the output stage is empty");

  a_ready_when_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input blocked while the output word is being taken");

  a_no_word_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output word present right after reset");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.left_speed != 9'h100) && (out_ch.right_speed != 9'h100))
    else $error("speed word outside -255..255");

endmodule
